### hdl/tlbpt_pkg.sv
// ----------------------------------------------------------------------------
// tlbpt_pkg
// Shared sizes and types of the TLB and page table translator.
// ----------------------------------------------------------------------------
`default_nettype none

package tlbpt_pkg;

	localparam int ADDR_W       = 16;
	localparam int OFFSET_WIDTH = 8;
	localparam int PAGE_COUNT   = 256;
	localparam int FRAME_TOTAL  = 128;
	localparam int TLB_ENTRIES  = 16;

	localparam int PAGE_W     = ADDR_W - OFFSET_WIDTH;
	localparam int PAGE_IDX_W = $clog2(PAGE_COUNT);
	localparam int FRAME_W    = $clog2(FRAME_TOTAL);
	localparam int TLB_IDX_W  = $clog2(TLB_ENTRIES);
	localparam int PHYS_W     = 15;
	localparam int OUT_PAGE_W = 8;
	localparam int CNT_W      = 16;

	typedef logic [PAGE_W-1:0]  page_t;
	typedef logic [FRAME_W-1:0] frame_t;

	// lookup result of the tlb
	typedef struct packed {
		logic   hit;
		frame_t frame;
	} tlb_look_t;

	// update command for the tlb, drop applied before insert
	typedef struct packed {
		logic   drop;
		page_t  drop_page;
		logic   ins;
		page_t  ins_page;
		frame_t ins_frame;
	} tlb_upd_t;

endpackage

`default_nettype wire

### hdl/tlb_page_table_translator.sv
// ----------------------------------------------------------------------------
// tlb_page_table_translator
// Address translation through a TLB backed by a page table, FIFO replacement.
// ----------------------------------------------------------------------------
// Usage:
//   input channel in_valid/in_ready carries virt_addr; the upper bits
//   name the page, the low OFFSET_WIDTH bits the offset.
//   output channel out_valid/out_ready carries one result per input transfer:
//   physical address, hit and fault flags, page to fetch, evicted page and
//   the saturating hit and fault totals after the item.
//   an item passes the transfer edge, a read state in which the page
//   table and frame owner memories return their registered read data,
//   and a resolve state that updates TLB, memories and counters and loads
//   the output register. A new item is taken only after the previous one
//   has left its resolve state.
//   the output register lets the next item be taken while a result waits;
//   if the receiver stalls, the following item holds in its resolve cycle.
//   reset empties the TLB and the page table (valid bits in flip-flops, no
//   clearing pass) and zeroes the frame pointer and the counters; a frame
//   owner entry is valid once the frame pointer has wrapped past it.
// ----------------------------------------------------------------------------
`default_nettype none

module tlb_page_table_translator import tlbpt_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [ADDR_W-1:0]     virt_addr,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [PHYS_W-1:0]          phys_addr,
	output logic                       tlb_hit,
	output logic                       page_fault,
	output logic [OUT_PAGE_W-1:0]      fetch_page,
	output logic                       evicted_valid,
	output logic [OUT_PAGE_W-1:0]      evicted_page,
	output logic [CNT_W-1:0]           hit_total,
	output logic [CNT_W-1:0]           fault_total
);

	localparam logic [1:0] ST_IDLE    = 2'd0;
	localparam logic [1:0] ST_READ    = 2'd1;
	localparam logic [1:0] ST_RESOLVE = 2'd2;

	logic [1:0]              state_q;
	page_t                   page_q;
	logic [OFFSET_WIDTH-1:0] offset_q;
	frame_t                  next_frame_q;
	logic                    wrapped_q;
	logic [CNT_W-1:0]        hit_cnt_q;
	logic [CNT_W-1:0]        fault_cnt_q;
	logic [PAGE_COUNT-1:0]   map_vld_q;
	logic [PAGE_COUNT-1:0]   map_vld_d;

	logic [PAGE_IDX_W-1:0] pidx;
	frame_t                map_rdata;
	page_t                 own_rdata;
	tlb_look_t             look;
	tlb_upd_t              upd;
	logic                  page_ok;
	logic                  map_hit;
	logic                  own_vld;
	logic                  fault;
	logic                  go;
	frame_t                frame;
	logic [CNT_W-1:0]      hit_cnt_d;
	logic [CNT_W-1:0]      fault_cnt_d;
	logic [FRAME_W+OFFSET_WIDTH-1:0] pa_full;

	assign in_ready = (state_q == ST_IDLE);
	assign pidx     = PAGE_IDX_W'(page_q);
	assign page_ok  = (32'(page_q) < PAGE_COUNT);
	assign map_hit  = map_vld_q[pidx];
	// frames are handed out in order, so the next one is owned once wrapped
	assign own_vld  = wrapped_q;
	assign go       = (state_q == ST_RESOLVE) && (!out_valid || out_ready);
	assign fault    = page_ok && !look.hit && !map_hit;

	always_comb begin
		frame = '0;
		if (page_ok) begin
			priority if (look.hit) begin
				frame = look.frame;
			end else if (map_hit) begin
				frame = map_rdata;
			end else begin
				frame = next_frame_q;
			end
		end
	end

	always_comb begin
		hit_cnt_d   = hit_cnt_q;
		fault_cnt_d = fault_cnt_q;
		if (page_ok && look.hit && hit_cnt_q != '1) begin
			hit_cnt_d = hit_cnt_q + 1'b1;
		end
		if (fault && fault_cnt_q != '1) begin
			fault_cnt_d = fault_cnt_q + 1'b1;
		end
	end

	// old owner of the reused frame leaves the page table first
	always_comb begin
		map_vld_d = map_vld_q;
		if (go && fault) begin
			if (own_vld) begin
				map_vld_d[PAGE_IDX_W'(own_rdata)] = 1'b0;
			end
			map_vld_d[pidx] = 1'b1;
		end
	end

	always_comb begin
		upd.drop      = go && fault && own_vld;
		upd.drop_page = own_rdata;
		upd.ins       = go && page_ok && !look.hit;
		upd.ins_page  = page_q;
		upd.ins_frame = frame;
	end

	assign pa_full = {frame, offset_q};

	tlbpt_tlb u_tlb (
		.clk    (clk),
		.arst_n (arst_n),
		.page   (page_q),
		.look   (look),
		.upd    (upd)
	);

	tlbpt_ram #(
		.WIDTH (FRAME_W),
		.DEPTH (PAGE_COUNT)
	) u_page_map (
		.clk   (clk),
		.we    (go && fault),
		.waddr (pidx),
		.wdata (next_frame_q),
		.raddr (pidx),
		.rdata (map_rdata)
	);

	tlbpt_ram #(
		.WIDTH (PAGE_W),
		.DEPTH (FRAME_TOTAL)
	) u_frame_owner (
		.clk   (clk),
		.we    (go && fault),
		.waddr (next_frame_q),
		.wdata (page_q),
		.raddr (next_frame_q),
		.rdata (own_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			next_frame_q <= '0;
			wrapped_q    <= 1'b0;
			hit_cnt_q    <= '0;
			fault_cnt_q  <= '0;
			map_vld_q    <= '0;
			out_valid    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_RESOLVE;
				end
				ST_RESOLVE: begin
					if (go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (go) begin
				out_valid   <= 1'b1;
				hit_cnt_q   <= hit_cnt_d;
				fault_cnt_q <= fault_cnt_d;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end

			map_vld_q <= map_vld_d;

			if (go && fault) begin
				if (next_frame_q == FRAME_W'(FRAME_TOTAL - 1)) begin
					next_frame_q <= '0;
					wrapped_q    <= 1'b1;
				end else begin
					next_frame_q <= next_frame_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			page_q   <= virt_addr[ADDR_W-1:OFFSET_WIDTH];
			offset_q <= virt_addr[OFFSET_WIDTH-1:0];
		end
		if (go) begin
			phys_addr     <= PHYS_W'(pa_full);
			tlb_hit       <= page_ok && look.hit;
			page_fault    <= fault;
			fetch_page    <= fault ? OUT_PAGE_W'(page_q) : '0;
			evicted_valid <= fault && own_vld;
			evicted_page  <= (fault && own_vld) ? OUT_PAGE_W'(own_rdata) : '0;
			hit_total     <= hit_cnt_d;
			fault_total   <= fault_cnt_d;
		end
	end

endmodule

`default_nettype wire

### hdl/tlbpt_ram.sv
// ----------------------------------------------------------------------------
// tlbpt_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tlbpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### hdl/tlbpt_tlb.sv
// ----------------------------------------------------------------------------
// tlbpt_tlb
// Fully associative TLB with FIFO insertion and invalidation by page.
// ----------------------------------------------------------------------------
`default_nettype none

module tlbpt_tlb import tlbpt_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire page_t     page,
	output tlb_look_t      look,
	input  wire tlb_upd_t  upd
);

	logic [TLB_ENTRIES-1:0] vld_q;
	logic [TLB_ENTRIES-1:0] vld_d;
	page_t                  tag_q   [TLB_ENTRIES];
	frame_t                 frame_q [TLB_ENTRIES];
	logic [TLB_IDX_W-1:0]   ptr_q;

	// lowest matching entry wins
	always_comb begin
		look = '0;
		for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
			if (vld_q[i] && tag_q[i] == page) begin
				look.hit   = 1'b1;
				look.frame = frame_q[i];
			end
		end
	end

	// drop first, then the insert may reuse the same slot
	always_comb begin
		vld_d = vld_q;
		for (int i = 0; i < TLB_ENTRIES; i++) begin
			if (upd.drop && vld_q[i] && tag_q[i] == upd.drop_page) begin
				vld_d[i] = 1'b0;
			end
		end
		if (upd.ins) begin
			vld_d[ptr_q] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			ptr_q <= '0;
		end else begin
			vld_q <= vld_d;
			if (upd.ins) begin
				if (ptr_q == TLB_IDX_W'(TLB_ENTRIES - 1)) begin
					ptr_q <= '0;
				end else begin
					ptr_q <= ptr_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd.ins) begin
			tag_q[ptr_q]   <= upd.ins_page;
			frame_q[ptr_q] <= upd.ins_frame;
		end
	end

endmodule

`default_nettype wire

### hdl/tlbpt_checker.sv
// ----------------------------------------------------------------------------
// tlbpt_checker
// Port level checks of the translator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tlbpt_checker import tlbpt_pkg::*; (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  in_valid,
	input wire logic                  in_ready,
	input wire logic [ADDR_W-1:0]     virt_addr,
	input wire logic                  out_valid,
	input wire logic                  out_ready,
	input wire logic [PHYS_W-1:0]     phys_addr,
	input wire logic                  tlb_hit,
	input wire logic                  page_fault,
	input wire logic [OUT_PAGE_W-1:0] fetch_page,
	input wire logic                  evicted_valid,
	input wire logic [OUT_PAGE_W-1:0] evicted_page,
	input wire logic [CNT_W-1:0]      hit_total,
	input wire logic [CNT_W-1:0]      fault_total
);

	// a waiting input holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(virt_addr))
		else $error("waiting input changed");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(phys_addr)
			&& $stable(tlb_hit) && $stable(page_fault) && $stable(fetch_page)
			&& $stable(evicted_valid) && $stable(evicted_page)
			&& $stable(hit_total) && $stable(fault_total))
		else $error("stalled result changed");

	// one item at a time: no transfer right after a transfer
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in flight");

	a_hit_xor_fault: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(tlb_hit && page_fault))
		else $error("hit and fault both set");

	a_evict_on_fault: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && evicted_valid |-> page_fault)
		else $error("eviction without a fault");

endmodule

bind tlb_page_table_translator tlbpt_checker u_tlbpt_checker (.*);

`default_nettype wire

### tb/sv/tlb_page_table_translator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tlb_page_table_translator_tb
// Self-checking bench for the TLB and page table translator. Addresses go in
// through valid/ready with random idle bursts on both channels. A scoreboard
// keeps its own TLB, page table, frame owner table and counters, predicts
// each result and compares every field of what comes out.
// ----------------------------------------------------------------------------

module tlb_page_table_translator_tb;
	import tlbpt_pkg::*;

	localparam int HALF_PERIOD   = 5;
	localparam int RANDOM_ITEMS  = 1426;
	localparam int HISTORY_DEPTH = 120;
	localparam int STALL_LIMIT   = 2000;
	localparam int DRAIN_CYCLES  = 10;

	typedef struct packed {
		logic [PHYS_W-1:0]     phys;
		logic                  hit;
		logic                  fault;
		logic [OUT_PAGE_W-1:0] fetch;
		logic                  ev_valid;
		logic [OUT_PAGE_W-1:0] ev_page;
		logic [CNT_W-1:0]      hits;
		logic [CNT_W-1:0]      faults;
	} translation_t;

	class translation_scoreboard;
		bit                   tag_ok[TLB_ENTRIES];
		page_t                tag_page[TLB_ENTRIES];
		frame_t               tag_frame[TLB_ENTRIES];
		logic [TLB_IDX_W-1:0] insert_slot;
		bit                   map_ok[PAGE_COUNT];
		frame_t               map_frame[PAGE_COUNT];
		bit                   owner_ok[FRAME_TOTAL];
		page_t                owner_page[FRAME_TOTAL];
		frame_t               next_free;
		logic [CNT_W-1:0]     hit_count;
		logic [CNT_W-1:0]     fault_count;
		translation_t         expected_q[$];
		int                   fail_count;

		function new();
			for (int i = 0; i < TLB_ENTRIES; i++) begin
				tag_ok[i] = 1'b0;
				tag_page[i] = '0;
				tag_frame[i] = '0;
			end
			for (int i = 0; i < PAGE_COUNT; i++) begin
				map_ok[i] = 1'b0;
				map_frame[i] = '0;
			end
			for (int i = 0; i < FRAME_TOTAL; i++) begin
				owner_ok[i] = 1'b0;
				owner_page[i] = '0;
			end
			insert_slot = '0;
			next_free = '0;
			hit_count = '0;
			fault_count = '0;
			fail_count = 0;
		endfunction

		// translate one accepted address and queue the result it must give
		function void note_address(logic [ADDR_W-1:0] addr);
			page_t                   page;
			logic [OFFSET_WIDTH-1:0] offset;
			frame_t                  frame;
			bit                      found;
			translation_t            res;
			page = addr[ADDR_W-1:OFFSET_WIDTH];
			offset = addr[OFFSET_WIDTH-1:0];
			frame = '0;
			found = 1'b0;
			res = '0;
			for (int i = 0; i < TLB_ENTRIES; i++) begin
				if (!found && tag_ok[i] && tag_page[i] == page) begin
					frame = tag_frame[i];
					found = 1'b1;
				end
			end
			if (found) begin
				res.hit = 1'b1;
				if (hit_count != '1)
					hit_count++;
			end else begin
				if (map_ok[page]) begin
					frame = map_frame[page];
				end else begin
					res.fault = 1'b1;
					res.fetch = OUT_PAGE_W'(page);
					frame = next_free;
					// frame reused: its old page leaves the table and the tlb
					if (owner_ok[frame]) begin
						res.ev_valid = 1'b1;
						res.ev_page = OUT_PAGE_W'(owner_page[frame]);
						map_ok[owner_page[frame]] = 1'b0;
						for (int i = 0; i < TLB_ENTRIES; i++)
							if (tag_ok[i] && tag_page[i] == owner_page[frame])
								tag_ok[i] = 1'b0;
					end
					map_ok[page] = 1'b1;
					map_frame[page] = frame;
					owner_ok[frame] = 1'b1;
					owner_page[frame] = page;
					next_free = frame + 1'b1;
					if (fault_count != '1)
						fault_count++;
				end
				tag_ok[insert_slot] = 1'b1;
				tag_page[insert_slot] = page;
				tag_frame[insert_slot] = frame;
				insert_slot = insert_slot + 1'b1;
			end
			res.phys = PHYS_W'({frame, offset});
			res.hits = hit_count;
			res.faults = fault_count;
			expected_q.push_back(res);
		endfunction

		function void compare_field(string name, longint unsigned exp_val,
				longint unsigned act_val);
			if (exp_val != act_val) begin
				$display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, exp_val,
					act_val);
				fail_count++;
			end
		endfunction

		function void check_result(translation_t act);
			translation_t exp_res;
			if (expected_q.size() == 0) begin
				$display("%0t: result with nothing expected, actual %p", $time, act);
				fail_count++;
				return;
			end
			exp_res = expected_q.pop_front();
			compare_field("phys_addr", exp_res.phys, act.phys);
			compare_field("tlb_hit", exp_res.hit, act.hit);
			compare_field("page_fault", exp_res.fault, act.fault);
			compare_field("fetch_page", exp_res.fetch, act.fetch);
			compare_field("evicted_valid", exp_res.ev_valid, act.ev_valid);
			compare_field("evicted_page", exp_res.ev_page, act.ev_page);
			compare_field("hit_total", exp_res.hits, act.hits);
			compare_field("fault_total", exp_res.faults, act.faults);
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [ADDR_W-1:0]     virt_addr = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [PHYS_W-1:0]     phys_addr;
	logic                  tlb_hit;
	logic                  page_fault;
	logic [OUT_PAGE_W-1:0] fetch_page;
	logic                  evicted_valid;
	logic [OUT_PAGE_W-1:0] evicted_page;
	logic [CNT_W-1:0]      hit_total;
	logic [CNT_W-1:0]      fault_total;

	translation_scoreboard sb = new();
	bit                    no_idle = 1'b0;
	int                    quiet_cycles = 0;
	page_t                 history[$];

	tlb_page_table_translator u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.virt_addr     (virt_addr),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.phys_addr     (phys_addr),
		.tlb_hit       (tlb_hit),
		.page_fault    (page_fault),
		.fetch_page    (fetch_page),
		.evicted_valid (evicted_valid),
		.evicted_page  (evicted_page),
		.hit_total     (hit_total),
		.fault_total   (fault_total)
	);

	always #HALF_PERIOD clk = ~clk;

	// offer one address, optionally after an idle burst, and wait for its transfer
	task automatic send_address(input logic [ADDR_W-1:0] addr);
		if (!no_idle && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid <= 1'b1;
		virt_addr <= addr;
		do @(posedge clk); while (!in_ready);
		sb.note_address(addr);
	endtask

	task automatic send_random_page();
		int    pick;
		int    span;
		page_t page;
		pick = $urandom_range(0, 99);
		span = history.size();
		if (pick < 45 && span > 0)
			page = history[span - 1 - $urandom_range(0, (span > 8) ? 7 : span - 1)];
		else if (pick < 70 && span > 0)
			page = history[$urandom_range(0, span - 1)];
		else
			page = page_t'($urandom_range(0, PAGE_COUNT - 1));
		history.push_back(page);
		if (history.size() > HISTORY_DEPTH)
			void'(history.pop_front());
		send_address({page, OFFSET_WIDTH'($urandom_range(0, (1 << OFFSET_WIDTH) - 1))});
	endtask

	// receiver side: stall bursts mixed with runs of steady acceptance
	initial begin
		@(posedge clk iff arst_n);
		forever begin
			@(posedge clk);
			if (!no_idle && $urandom_range(0, 11) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
			out_ready <= 1'b1;
			if (!no_idle)
				repeat ($urandom_range(0, 20)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result('{phys_addr, tlb_hit, page_fault, fetch_page,
				evicted_valid, evicted_page, hit_total, fault_total});
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// address extremes, then tlb hits on the same pages
		send_address(16'h0000);
		send_address(16'hFFFF);
		send_address(16'h0000);
		send_address(16'hFF00);
		send_address(16'h00FF);
		send_address(16'h12AB);
		send_address(16'hAA55);
		send_address(16'h7F80);
		// new pages push the first pages out of the tlb
		for (int i = 0; i < 14; i++)
			send_address({8'(8'h20 + i), 8'(i * 17)});
		// still in the page table, so tlb misses without faults
		send_address(16'h0001);
		send_address(16'hFF7F);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n >= RANDOM_ITEMS * 85 / 100)
				no_idle = 1'b1;
			send_random_page();
		end
		in_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
